/* hw/rtl/prdg_pkg.sv */
`timescale 1ns / 1ps

package prdg_pkg;

  localparam int PIX_W      = 12;
  localparam int COMP_W     = 21;
  localparam int DIR_W      = 20;
  localparam int SUB_W      = 3;
  localparam int REG_W      = 24;
  localparam int SPP_W      = 4;
  localparam int CFG_DATA_W = 63;
  localparam int CFG_IDX_W  = 3;

  // normalization constants: magnitudes are scaled into [2^29, 2^30)
  localparam int NORM_W     = 30;
  localparam int FRAC_SHIFT = 19;
  localparam int NDIV_STEPS = 20;
  localparam int ROOT_W     = 64;
  localparam int DEN_W      = 33;

  localparam logic signed [DIR_W-1:0] DIR_ONE = 20'sd262144;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASIS_U   = 3'd0,
    REG_BASIS_V   = 3'd1,
    REG_BASIS_W   = 3'd2,
    REG_VIEW_DIST = 3'd3,
    REG_SPACING   = 3'd4,
    REG_SHIFT_X   = 3'd5,
    REG_IMAGE     = 3'd6,
    REG_SPP       = 3'd7
  } reg_idx_t;

  localparam logic [CFG_DATA_W-1:0] RST_BASIS_U   = 63'd262144;
  localparam logic [CFG_DATA_W-1:0] RST_BASIS_V   = 63'd549755813888;
  localparam logic [CFG_DATA_W-1:0] RST_BASIS_W   = 63'd1152921504606846976;
  localparam logic [REG_W-1:0]      RST_VIEW_DIST = 24'd128000;
  localparam logic [REG_W-1:0]      RST_SPACING   = 24'd65536;
  localparam logic [REG_W-1:0]      RST_SHIFT_X   = 24'd0;
  localparam logic [REG_W-1:0]      RST_IMAGE     = 24'd1048832;
  localparam logic [SPP_W-1:0]      RST_SPP       = 4'd1;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] basis_u;
    logic [CFG_DATA_W-1:0] basis_v;
    logic [CFG_DATA_W-1:0] basis_w;
    logic [REG_W-1:0]      view_distance;
    logic [REG_W-1:0]      sample_spacing;
    logic [REG_W-1:0]      shift_x;
    logic [REG_W-1:0]      image_size;
    logic [SPP_W-1:0]      samples_per_side;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] col;
  } pix_t;

  // head of the pixel queue as seen by the back end
  typedef struct packed {
    logic valid;
    pix_t pix;
  } head_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_T,
    S_MUL,
    S_PREP,
    S_DIV,
    S_COORD,
    S_PROD,
    S_ACC,
    S_MAG,
    S_SCALE,
    S_SQ,
    S_SUM,
    S_SQRT,
    S_DPREP,
    S_NDIV,
    S_FIN,
    S_EMIT
  } back_state_t;

  // pick one signed Q2.18 component out of a packed basis vector
  function automatic logic signed [COMP_W-1:0] get_comp(input logic [CFG_DATA_W-1:0] v,
                                                        input logic [1:0] i);
    logic signed [COMP_W-1:0] c;
    case (i)
      2'd0:    c = $signed(v[COMP_W-1:0]);
      2'd1:    c = $signed(v[2*COMP_W-1:COMP_W]);
      default: c = $signed(v[3*COMP_W-1:2*COMP_W]);
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/prdg_front.sv */
`timescale 1ns / 1ps

module prdg_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [prdg_pkg::PIX_W-1:0]      in_pixel_row,
  input  logic [prdg_pkg::PIX_W-1:0]      in_pixel_col,
  input  logic                            pop,
  output prdg_pkg::head_t                 head
);

  localparam int DEPTH = 2;

  prdg_pkg::pix_t ent_r [DEPTH];
  logic           wr_r, wr_nxt;
  logic           rd_r, rd_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           accept;

  assign in_stall   = (cnt_r == 2'(DEPTH));
  assign accept     = in_valid && !in_stall;
  assign head.valid = (cnt_r != 2'd0);
  assign head.pix   = ent_r[rd_r];

  // advance pointers and fill count
  always_comb begin
    wr_nxt  = accept ? ~wr_r : wr_r;
    rd_nxt  = pop ? ~rd_r : rd_r;
    cnt_nxt = cnt_r;
    case ({accept, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // store the accepted pixel word
  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r[wr_r].row <= in_pixel_row;
      ent_r[wr_r].col <= in_pixel_col;
    end
  end

endmodule

/* hw/rtl/prdg_back.sv */
`timescale 1ns / 1ps

module prdg_back #(
  parameter int MAX_SIDE   = 8,
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  prdg_pkg::cfg_t                        cfg,
  input  prdg_pkg::head_t                       head,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [prdg_pkg::DIR_W-1:0]     out_dir_x,
  output logic signed [prdg_pkg::DIR_W-1:0]     out_dir_y,
  output logic signed [prdg_pkg::DIR_W-1:0]     out_dir_z,
  output logic [prdg_pkg::SUB_W-1:0]            out_sub_row,
  output logic [prdg_pkg::SUB_W-1:0]            out_sub_col,
  output logic                                  out_last_sample
);

  localparam int NW   = $clog2(MAX_SIDE + 1);
  localparam int SUBW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int MB   = (COORD_BITS > 13) ? COORD_BITS : 13;
  localparam int TW   = NW + MB + 1;
  localparam int PW   = prdg_pkg::REG_W + 1 + TW;
  localparam int AW   = PW + 2;
  localparam int QW   = AW - 10;
  localparam int CW   = QW + 1;
  localparam int XW   = ((CW > prdg_pkg::REG_W) ? CW : prdg_pkg::REG_W) + 1;
  localparam int UW   = XW + prdg_pkg::COMP_W;
  localparam int VW   = CW + prdg_pkg::COMP_W;
  localparam int WW   = prdg_pkg::REG_W + 1 + prdg_pkg::COMP_W;
  localparam int CCW  = XW + prdg_pkg::COMP_W + 2;
  localparam int CNTW = $clog2(QW + 1);
  localparam int IW   = prdg_pkg::REG_W + COORD_BITS;
  localparam int NMW  = prdg_pkg::NORM_W;
  localparam int NUMW = NMW + prdg_pkg::FRAC_SHIFT + 1;
  localparam int NQW  = prdg_pkg::NDIV_STEPS;
  localparam int DNW  = prdg_pkg::DEN_W;
  localparam int RW   = prdg_pkg::ROOT_W;
  localparam int DW   = prdg_pkg::DIR_W;

  prdg_pkg::back_state_t state_r, state_nxt;

  prdg_pkg::pix_t           pix_r;
  logic [NW-1:0]            n_r;
  logic [SUBW-1:0]          p_r, q_r;
  logic                     sel_y_r;
  logic [1:0]               comp_r;
  logic [CNTW-1:0]          cnt_r;
  logic signed [TW-1:0]     t_r;
  logic signed [PW-1:0]     prod_r;
  logic                     neg_r;
  logic [QW-1:0]            dq_r;
  logic [NW-1:0]            drem_r;
  logic signed [CW-1:0]     y_r;
  logic signed [XW-1:0]     x_r;
  logic signed [UW-1:0]     pu_r;
  logic signed [VW-1:0]     pv_r;
  logic signed [WW-1:0]     pw_r;
  logic signed [CCW-1:0]    c_r [3];
  logic [CCW-1:0]           m_r [3];
  logic                     sgn_r [3];
  logic [2*NMW-1:0]         sq_r [3];
  logic [RW-1:0]            rad_r, root_r, bit_r;
  logic [DNW-1:0]           nrem_r [3];
  logic [NQW-1:0]           nq_r [3];
  logic signed [DW-1:0]     dir_r [3];

  logic                     out_valid_r;
  logic signed [DW-1:0]     out_dir_r [3];
  logic [prdg_pkg::SUB_W-1:0] out_sub_row_r, out_sub_col_r;
  logic                     out_last_r;

  // combinational helpers
  logic [NW-1:0]            n_cfg;
  logic [IW-1:0]            img_ext;
  logic [COORD_BITS-1:0]    res_sel;
  logic [prdg_pkg::PIX_W-1:0] idx_sel;
  logic [SUBW-1:0]          sub_sel;
  logic [TW-1:0]            t_calc;
  logic signed [PW-1:0]     prod_calc;
  logic [PW-1:0]            mag_calc;
  logic [AW-1:0]            a_calc;
  logic [NW:0]              dtmp;
  logic                     dge;
  logic signed [CW-1:0]     coord_calc;
  logic signed [prdg_pkg::COMP_W-1:0] u_c, v_c, w_c;
  logic signed [CCW-1:0]    c_calc;
  logic [CCW-1:0]           big;
  logic                     big_hi, big_lo, big_zero;
  logic [RW-1:0]            rb;
  logic                     rge;
  logic [DNW-1:0]           den;
  logic [NUMW-1:0]          num [3];
  logic [DNW:0]             ntmp [3];
  logic                     nge [3];
  logic                     last_q, last_p, slot_free, emit_go;

  // clamp the sub-sample count
  always_comb begin
    if (cfg.samples_per_side == '0) begin
      n_cfg = NW'(1);
    end else if ({1'b0, cfg.samples_per_side} > 5'(MAX_SIDE)) begin
      n_cfg = NW'(MAX_SIDE);
    end else begin
      n_cfg = NW'(cfg.samples_per_side);
    end
  end

  // plane coordinate numerator t = 2n*idx - n*res + 2*sub + 1
  assign img_ext   = IW'(cfg.image_size);
  assign res_sel   = sel_y_r ? img_ext[2*COORD_BITS-1:COORD_BITS] : img_ext[COORD_BITS-1:0];
  assign idx_sel   = sel_y_r ? pix_r.row : pix_r.col;
  assign sub_sel   = sel_y_r ? p_r : q_r;
  assign t_calc    = ((TW'(n_r) * TW'(idx_sel)) << 1) + (TW'(sub_sel) << 1) + TW'(1)
                     - TW'(n_r) * TW'(res_sel);
  assign prod_calc = $signed({1'b0, cfg.sample_spacing}) * t_r;

  // round half away: floor((2|st| + 512n) / 1024 / n)
  assign mag_calc  = prod_r[PW-1] ? (~prod_r + 1'b1) : prod_r;
  assign a_calc    = AW'({mag_calc, 1'b0}) + (AW'(n_r) << 9);

  // one quotient bit per cycle against n
  assign dtmp       = {drem_r, dq_r[QW-1]};
  assign dge        = (dtmp >= {1'b0, n_r});
  assign coord_calc = neg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});

  // basis components for the current lane
  assign u_c    = prdg_pkg::get_comp(cfg.basis_u, comp_r);
  assign v_c    = prdg_pkg::get_comp(cfg.basis_v, comp_r);
  assign w_c    = prdg_pkg::get_comp(cfg.basis_w, comp_r);
  assign c_calc = CCW'(pu_r) + CCW'(pv_r) - CCW'(pw_r);

  // largest magnitude drives the scaling
  always_comb begin
    big = m_r[0];
    if (m_r[1] > big) big = m_r[1];
    if (m_r[2] > big) big = m_r[2];
  end
  assign big_hi   = |big[CCW-1:NMW];
  assign big_lo   = !big_hi && !big[NMW-1];
  assign big_zero = (big == '0);

  // square root step
  assign rb  = root_r + bit_r;
  assign rge = (rad_r >= rb);

  // quotient step per lane
  assign den = {root_r[DNW-2:0], 1'b0};
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i]  = (NUMW'(m_r[i][NMW-1:0]) << prdg_pkg::FRAC_SHIFT) + NUMW'(root_r[DNW-2:0]);
      ntmp[i] = {nrem_r[i], nq_r[i][NQW-1]};
      nge[i]  = (ntmp[i] >= {1'b0, den});
    end
  end

  assign last_q    = (NW'(q_r) == n_r - NW'(1));
  assign last_p    = (NW'(p_r) == n_r - NW'(1));
  assign slot_free = !out_valid_r || !out_stall;

  // sequencer next state and handshake controls
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    emit_go   = 1'b0;
    unique case (state_r)
      prdg_pkg::S_IDLE: begin
        if (head.valid) begin
          pop       = 1'b1;
          state_nxt = prdg_pkg::S_T;
        end
      end
      prdg_pkg::S_T:     state_nxt = prdg_pkg::S_MUL;
      prdg_pkg::S_MUL:   state_nxt = prdg_pkg::S_PREP;
      prdg_pkg::S_PREP:  state_nxt = prdg_pkg::S_DIV;
      prdg_pkg::S_DIV: begin
        if (cnt_r == CNTW'(QW - 1)) state_nxt = prdg_pkg::S_COORD;
      end
      prdg_pkg::S_COORD: state_nxt = sel_y_r ? prdg_pkg::S_T : prdg_pkg::S_PROD;
      prdg_pkg::S_PROD:  state_nxt = prdg_pkg::S_ACC;
      prdg_pkg::S_ACC:   state_nxt = (comp_r == 2'd2) ? prdg_pkg::S_MAG : prdg_pkg::S_PROD;
      prdg_pkg::S_MAG:   state_nxt = prdg_pkg::S_SCALE;
      prdg_pkg::S_SCALE: begin
        if (big_zero) begin
          state_nxt = prdg_pkg::S_EMIT;
        end else if (!big_hi && !big_lo) begin
          state_nxt = prdg_pkg::S_SQ;
        end
      end
      prdg_pkg::S_SQ:    state_nxt = prdg_pkg::S_SUM;
      prdg_pkg::S_SUM:   state_nxt = prdg_pkg::S_SQRT;
      prdg_pkg::S_SQRT: begin
        if (bit_r[0]) state_nxt = prdg_pkg::S_DPREP;
      end
      prdg_pkg::S_DPREP: state_nxt = prdg_pkg::S_NDIV;
      prdg_pkg::S_NDIV: begin
        if (cnt_r == CNTW'(NQW - 1)) state_nxt = prdg_pkg::S_FIN;
      end
      prdg_pkg::S_FIN:   state_nxt = prdg_pkg::S_EMIT;
      prdg_pkg::S_EMIT: begin
        if (slot_free) begin
          emit_go   = 1'b1;
          state_nxt = (last_q && last_p) ? prdg_pkg::S_IDLE : prdg_pkg::S_T;
        end
      end
      default: state_nxt = prdg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prdg_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers, loaded by state
  always_ff @(posedge clk) begin
    case (state_r)
      prdg_pkg::S_IDLE: begin
        pix_r   <= head.pix;
        n_r     <= n_cfg;
        p_r     <= '0;
        q_r     <= '0;
        sel_y_r <= 1'b1;
      end
      prdg_pkg::S_T:    t_r    <= $signed(t_calc);
      prdg_pkg::S_MUL:  prod_r <= prod_calc;
      prdg_pkg::S_PREP: begin
        neg_r  <= prod_r[PW-1];
        dq_r   <= a_calc[AW-1:10];
        drem_r <= '0;
        cnt_r  <= '0;
      end
      prdg_pkg::S_DIV: begin
        drem_r <= dge ? NW'(dtmp - {1'b0, n_r}) : dtmp[NW-1:0];
        dq_r   <= {dq_r[QW-2:0], dge};
        cnt_r  <= cnt_r + CNTW'(1);
      end
      prdg_pkg::S_COORD: begin
        if (sel_y_r) begin
          y_r     <= coord_calc;
          sel_y_r <= 1'b0;
        end else begin
          x_r    <= XW'(coord_calc) + XW'($signed(cfg.shift_x));
          comp_r <= 2'd0;
        end
      end
      prdg_pkg::S_PROD: begin
        pu_r <= x_r * u_c;
        pv_r <= y_r * v_c;
        pw_r <= $signed({1'b0, cfg.view_distance}) * w_c;
      end
      prdg_pkg::S_ACC: begin
        c_r[comp_r] <= c_calc;
        comp_r      <= comp_r + 2'd1;
      end
      prdg_pkg::S_MAG: begin
        for (int i = 0; i < 3; i++) begin
          sgn_r[i] <= c_r[i][CCW-1];
          m_r[i]   <= c_r[i][CCW-1] ? CCW'(-c_r[i]) : CCW'(c_r[i]);
        end
      end
      prdg_pkg::S_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          if (big_zero) begin
            dir_r[i] <= '0;
          end else if (big_hi) begin
            m_r[i] <= m_r[i] >> 1;
          end else if (big_lo) begin
            m_r[i] <= m_r[i] << 1;
          end
        end
      end
      prdg_pkg::S_SQ: begin
        for (int i = 0; i < 3; i++) begin
          sq_r[i] <= m_r[i][NMW-1:0] * m_r[i][NMW-1:0];
        end
      end
      prdg_pkg::S_SUM: begin
        rad_r  <= RW'(sq_r[0]) + RW'(sq_r[1]) + RW'(sq_r[2]);
        root_r <= '0;
        bit_r  <= RW'(1) << (RW - 2);
      end
      prdg_pkg::S_SQRT: begin
        rad_r  <= rge ? rad_r - rb : rad_r;
        root_r <= rge ? (root_r >> 1) + bit_r : root_r >> 1;
        bit_r  <= bit_r >> 2;
      end
      prdg_pkg::S_DPREP: begin
        for (int i = 0; i < 3; i++) begin
          nrem_r[i] <= DNW'(num[i][NUMW-1:NQW]);
          nq_r[i]   <= num[i][NQW-1:0];
        end
        cnt_r <= '0;
      end
      prdg_pkg::S_NDIV: begin
        for (int i = 0; i < 3; i++) begin
          nrem_r[i] <= nge[i] ? DNW'(ntmp[i] - {1'b0, den}) : ntmp[i][DNW-1:0];
          nq_r[i]   <= {nq_r[i][NQW-2:0], nge[i]};
        end
        cnt_r <= cnt_r + CNTW'(1);
      end
      prdg_pkg::S_FIN: begin
        for (int i = 0; i < 3; i++) begin
          dir_r[i] <= sgn_r[i] ? -$signed(DW'(nq_r[i])) : $signed(DW'(nq_r[i]));
        end
      end
      prdg_pkg::S_EMIT: begin
        if (emit_go) begin
          if (last_q) begin
            q_r     <= '0;
            p_r     <= p_r + SUBW'(1);
            sel_y_r <= 1'b1;
          end else begin
            q_r <= q_r + SUBW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // output word register; hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_dir_r     <= dir_r;
      out_sub_row_r <= prdg_pkg::SUB_W'(p_r);
      out_sub_col_r <= prdg_pkg::SUB_W'(q_r);
      out_last_r    <= last_q && last_p;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_dir_x       = out_dir_r[0];
  assign out_dir_y       = out_dir_r[1];
  assign out_dir_z       = out_dir_r[2];
  assign out_sub_row     = out_sub_row_r;
  assign out_sub_col     = out_sub_col_r;
  assign out_last_sample = out_last_r;

endmodule

/* hw/rtl/pinhole_ray_direction_generator_unit.sv */
// channel | direction | handshake          | word
// in      | input     | in_valid/in_stall  | in_pixel_row, in_pixel_col
// out     | output    | out_valid/out_stall| out_dir_x/y/z, out_sub_row/col, out_last_sample
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Each sub-sample runs a bit-serial coordinate divide by n, a one-bit-a-cycle
// normalizing shift, a square root and three parallel quotients.
// A new sub-sample row first adds the divide for its y coordinate.
// A two-word pixel queue takes input while the back end works or the output stalls.
// Reset is synchronous, active low, and restores the documented register values.
`timescale 1ns / 1ps

module pinhole_ray_direction_generator_unit #(
  parameter int MAX_SIDE   = 8,
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [prdg_pkg::PIX_W-1:0]            in_pixel_row,
  input  logic [prdg_pkg::PIX_W-1:0]            in_pixel_col,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [prdg_pkg::DIR_W-1:0]     out_dir_x,
  output logic signed [prdg_pkg::DIR_W-1:0]     out_dir_y,
  output logic signed [prdg_pkg::DIR_W-1:0]     out_dir_z,
  output logic [prdg_pkg::SUB_W-1:0]            out_sub_row,
  output logic [prdg_pkg::SUB_W-1:0]            out_sub_col,
  output logic                                  out_last_sample,
  input  logic                                  cfg_we,
  input  logic [prdg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [prdg_pkg::CFG_DATA_W-1:0]       cfg_data
);

  prdg_pkg::cfg_t  cfg_r;
  prdg_pkg::head_t head;
  logic            pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.basis_u          <= prdg_pkg::RST_BASIS_U;
      cfg_r.basis_v          <= prdg_pkg::RST_BASIS_V;
      cfg_r.basis_w          <= prdg_pkg::RST_BASIS_W;
      cfg_r.view_distance    <= prdg_pkg::RST_VIEW_DIST;
      cfg_r.sample_spacing   <= prdg_pkg::RST_SPACING;
      cfg_r.shift_x          <= prdg_pkg::RST_SHIFT_X;
      cfg_r.image_size       <= prdg_pkg::RST_IMAGE;
      cfg_r.samples_per_side <= prdg_pkg::RST_SPP;
    end else if (cfg_we) begin
      unique case (prdg_pkg::reg_idx_t'(cfg_index))
        prdg_pkg::REG_BASIS_U:   cfg_r.basis_u        <= cfg_data;
        prdg_pkg::REG_BASIS_V:   cfg_r.basis_v        <= cfg_data;
        prdg_pkg::REG_BASIS_W:   cfg_r.basis_w        <= cfg_data;
        prdg_pkg::REG_VIEW_DIST: cfg_r.view_distance  <= cfg_data[prdg_pkg::REG_W-1:0];
        prdg_pkg::REG_SPACING:   cfg_r.sample_spacing <= cfg_data[prdg_pkg::REG_W-1:0];
        prdg_pkg::REG_SHIFT_X:   cfg_r.shift_x        <= cfg_data[prdg_pkg::REG_W-1:0];
        prdg_pkg::REG_IMAGE:     cfg_r.image_size     <= cfg_data[prdg_pkg::REG_W-1:0];
        prdg_pkg::REG_SPP:       cfg_r.samples_per_side <= cfg_data[prdg_pkg::SPP_W-1:0];
        default: ;
      endcase
    end
  end

  prdg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pixel_row (in_pixel_row),
    .in_pixel_col (in_pixel_col),
    .pop          (pop),
    .head         (head)
  );

  prdg_back #(
    .MAX_SIDE   (MAX_SIDE),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dir_x       (out_dir_x),
    .out_dir_y       (out_dir_y),
    .out_dir_z       (out_dir_z),
    .out_sub_row     (out_sub_row),
    .out_sub_col     (out_sub_col),
    .out_last_sample (out_last_sample)
  );

endmodule

/* hw/rtl/prdg_checker.sv */
`timescale 1ns / 1ps

module prdg_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [prdg_pkg::DIR_W-1:0]     out_dir_x,
  input logic signed [prdg_pkg::DIR_W-1:0]     out_dir_y,
  input logic signed [prdg_pkg::DIR_W-1:0]     out_dir_z,
  input logic [prdg_pkg::SUB_W-1:0]            out_sub_row,
  input logic [prdg_pkg::SUB_W-1:0]            out_sub_col,
  input logic                                  out_last_sample
);

  // no word may be offered right after reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // the empty pixel queue takes a word right after reset
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid &&
      $stable({out_dir_x, out_dir_y, out_dir_z, out_sub_row, out_sub_col, out_last_sample}))
    else $error("stalled output word changed");

  // normalized components stay within unit magnitude
  a_dir_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      out_dir_x <= prdg_pkg::DIR_ONE && out_dir_x >= -prdg_pkg::DIR_ONE &&
      out_dir_y <= prdg_pkg::DIR_ONE && out_dir_y >= -prdg_pkg::DIR_ONE &&
      out_dir_z <= prdg_pkg::DIR_ONE && out_dir_z >= -prdg_pkg::DIR_ONE)
    else $error("direction component out of range");

  // the closing sub-sample sits on the grid diagonal corner
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_sample && !in_valid |-> out_sub_row == out_sub_col ||
      out_valid && out_last_sample && in_valid |-> out_sub_row == out_sub_col)
    else $error("last sample not at the grid corner");

endmodule

bind pinhole_ray_direction_generator_unit prdg_checker u_prdg_checker (.*);
